### rtl/assert_macros.svh
// shared assertion macros, clocked on i_clk and held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/rcid_pkg.sv
package rcid_pkg;

    // operation codes
    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_INC      = 3'd1;
    localparam logic [2:0] OP_DEC      = 3'd2;
    localparam logic [2:0] OP_QUERY    = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_SAT       = 3'd4;

    // commands to the freed-set unit
    typedef struct packed {
        logic prep;   // read the word holding i_id
        logic take;   // remove the smallest freed id, find the next one
        logic give;   // add i_id to the freed set
        logic clear;  // empty the set
    } t_fs_cmd;

endpackage

### rtl/rcid_free_set.sv
`include "assert_macros.svh"

module rcid_free_set #(
    parameter int ID_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcid_pkg::t_fs_cmd    i_cmd,
    input  logic [ID_BITS-1:0]   i_id,
    output logic [ID_BITS-1:0]   o_min,
    output logic                 o_busy
);

    localparam int FW_BITS = (ID_BITS > 6) ? 5 : ID_BITS - 1;
    localparam int FW      = 1 << FW_BITS;
    localparam int WA      = ID_BITS - FW_BITS;
    localparam logic [WA-1:0] LastWord = '1;

    // freed bitmap, FW ids per word
    logic [FW-1:0] mem [0:(1<<WA)-1];

    logic [FW-1:0]      r_rdata;
    logic [ID_BITS-1:0] r_min;
    logic               r_issue;
    logic               r_chk;
    logic [WA-1:0]      r_raddr;
    logic [WA-1:0]      r_chk_addr;
    logic               r_sweep;
    logic [WA-1:0]      r_swaddr;

    logic [WA-1:0]      id_word;
    logic [FW_BITS-1:0] id_bit;
    logic [WA-1:0]      min_word;
    logic [FW_BITS-1:0] min_bit;
    logic [FW-1:0]      taken;
    logic [FW-1:0]      given;
    logic [FW_BITS:0]   t_ffs;
    logic [FW_BITS:0]   s_ffs;
    logic               rd_en;
    logic [WA-1:0]      rd_addr;
    logic               wr_en;
    logic [WA-1:0]      wr_addr;
    logic [FW-1:0]      wr_data;

    // lowest set bit: {hit, index}
    function automatic logic [FW_BITS:0] first_set(input logic [FW-1:0] w);
        logic [FW_BITS:0] res;
        res = '0;
        for (int k = FW - 1; k >= 0; k--) begin
            if (w[k]) begin
                res = {1'b1, FW_BITS'(k)};
            end
        end
        return res;
    endfunction

    assign id_word  = i_id[ID_BITS-1:FW_BITS];
    assign id_bit   = i_id[FW_BITS-1:0];
    assign min_word = r_min[ID_BITS-1:FW_BITS];
    assign min_bit  = r_min[FW_BITS-1:0];
    assign taken    = r_rdata & ~(FW'(1) << min_bit);
    assign given    = r_rdata | (FW'(1) << id_bit);
    assign t_ffs    = first_set(taken);
    assign s_ffs    = first_set(r_rdata);

    assign rd_en   = i_cmd.prep | r_issue;
    assign rd_addr = r_issue ? r_raddr : id_word;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = id_word;
        wr_data = given;
        if (r_sweep) begin
            wr_en   = 1'b1;
            wr_addr = r_swaddr;
            wr_data = '0;
        end else if (i_cmd.take) begin
            wr_en   = 1'b1;
            wr_addr = min_word;
            wr_data = taken;
        end else if (i_cmd.give) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_raddr    <= r_raddr + 1'b1;
            r_chk_addr <= r_raddr;
        end
        if (i_cmd.take && !t_ffs[FW_BITS]) begin
            r_raddr <= min_word + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= '0;
            r_issue  <= 1'b0;
            r_chk    <= 1'b0;
            r_sweep  <= 1'b1;
            r_swaddr <= '0;
        end else begin
            if (r_sweep) begin
                r_swaddr <= r_swaddr + 1'b1;
                if (r_swaddr == LastWord) begin
                    r_sweep <= 1'b0;
                end
            end
            // upward scan: one word read per cycle, checked in the next cycle
            if (r_chk && s_ffs[FW_BITS]) begin
                r_min   <= {r_chk_addr, s_ffs[FW_BITS-1:0]};
                r_issue <= 1'b0;
                r_chk   <= 1'b0;
            end else begin
                r_chk <= r_issue;
                if (r_issue && r_raddr == LastWord) begin
                    r_issue <= 1'b0;
                end
            end
            if (i_cmd.clear) begin
                r_sweep  <= 1'b1;
                r_swaddr <= '0;
                r_min    <= '0;
            end
            if (i_cmd.give && (r_min == '0 || i_id < r_min)) begin
                r_min <= i_id;
            end
            if (i_cmd.take) begin
                if (t_ffs[FW_BITS]) begin
                    r_min <= {min_word, t_ffs[FW_BITS-1:0]};
                end else begin
                    r_min <= '0;
                    if (min_word != LastWord) begin
                        r_issue <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_min  = r_min;
    assign o_busy = r_sweep | r_issue | r_chk;

    `ASSERT_RST(a_fs_cmd_onehot, $onehot0(i_cmd), "free set: overlapping commands")
    `ASSERT_RST(a_fs_take_nonempty, i_cmd.take |-> r_min != '0, "free set: take from empty set")
    `ASSERT_RST(a_fs_cmd_idle, i_cmd != '0 |-> !o_busy, "free set: command while busy")

endmodule

### rtl/refcounted_id_allocator.sv
// Reference-counted id allocator: hands out ids 1..2^ID_BITS-1, reusing the smallest
// freed id first, and keeps a COUNT_BITS reference count per live id in a single-port
// entry memory with a registered read. Each request gives one result. A request's entry
// is read when taken and written back when its result is registered, which waits while
// the output is held; no new request is taken meanwhile. An allocate that empties the
// freed-bitmap word of the smallest freed id scans the later words upward, one word of
// 32 ids (half the ids if ID_BITS <= 6) per cycle, holding off requests until the scan
// ends. After reset and after a clear the entry memory is swept one entry per cycle, and
// no request is taken until it ends. Input tdata: op, ident; output tdata: new_ident,
// ref_count, present, status; each from the lowest bit up, zero-padded to whole bytes.
`include "assert_macros.svh"

module refcounted_id_allocator #(
    parameter int ID_BITS    = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // op[2:0], ident[ID_BITS-1:0]
    input  logic [((3+ID_BITS+7)/8)*8-1:0]               i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // new_ident[ID_BITS-1:0], ref_count[COUNT_BITS-1:0], present, status[2:0]
    output logic [((ID_BITS+COUNT_BITS+4+7)/8)*8-1:0]    o_m_axis_tdata
);

    localparam int OUT_W = ((ID_BITS + COUNT_BITS + 4 + 7) / 8) * 8;
    localparam logic [ID_BITS-1:0]    IdLast   = '1;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // entry: {live, count}
    logic [COUNT_BITS:0] ent_mem [0:(1<<ID_BITS)-1];

    t_state              r_state;
    logic [ID_BITS-1:0]  r_swaddr;
    logic [ID_BITS-1:0]  r_fresh;
    logic [2:0]          r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [COUNT_BITS:0] r_ent;
    logic                r_out_valid;
    logic [ID_BITS-1:0]  r_out_nid;
    logic [COUNT_BITS-1:0] r_out_cnt;
    logic                r_out_pres;
    logic [2:0]          r_out_st;

    logic [ID_BITS-1:0]    n_fresh;
    logic [ID_BITS-1:0]    n_nid;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  n_pres;
    logic [2:0]            n_st;

    logic [2:0]            in_op;
    logic [ID_BITS-1:0]    in_id;
    logic                  accept;
    logic                  out_free;
    logic                  fire;
    logic                  ent_live;
    logic [COUNT_BITS-1:0] ent_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic                  ent_we;
    logic [ID_BITS-1:0]    ent_wa;
    logic [COUNT_BITS:0]   ent_wd;
    logic [ID_BITS-1:0]    pick;
    rcid_pkg::t_fs_cmd     fs_cmd;
    logic [ID_BITS-1:0]    fs_id;
    logic [ID_BITS-1:0]    fs_min;
    logic                  fs_busy;

    assign in_op    = i_s_axis_tdata[2:0];
    assign in_id    = i_s_axis_tdata[3 +: ID_BITS];
    assign o_s_axis_tready = (r_state == S_IDLE) && !fs_busy;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign fire     = (r_state == S_EXEC) && out_free;

    assign ent_live = r_ent[COUNT_BITS];
    assign ent_cnt  = r_ent[COUNT_BITS-1:0];
    assign inc_cnt  = COUNT_BITS'(ent_cnt + 1'b1);
    assign dec_cnt  = COUNT_BITS'(ent_cnt - 1'b1);

    always_comb begin
        n_fresh      = r_fresh;
        n_nid        = '0;
        n_cnt        = '0;
        n_pres       = 1'b0;
        n_st         = rcid_pkg::ST_OK;
        ent_we       = 1'b0;
        ent_wa       = r_id;
        ent_wd       = {1'b0, ent_cnt};
        pick         = '0;
        fs_cmd       = '0;
        fs_cmd.prep  = accept;
        if (r_state == S_SWEEP) begin
            ent_we = 1'b1;
            ent_wa = r_swaddr;
            ent_wd = '0;
        end else if (fire) begin
            unique case (r_op)
                rcid_pkg::OP_ALLOC: begin
                    if (fs_min != '0) begin
                        pick        = fs_min;
                        fs_cmd.take = 1'b1;
                    end else if (r_fresh != '0) begin
                        pick    = r_fresh;
                        n_fresh = r_fresh + 1'b1;
                    end
                    if (pick == '0) begin
                        n_st = rcid_pkg::ST_FULL;
                    end else begin
                        ent_we = 1'b1;
                        ent_wa = pick;
                        ent_wd = {1'b1, COUNT_BITS'(1)};
                        n_nid  = pick;
                        n_cnt  = COUNT_BITS'(1);
                    end
                end
                rcid_pkg::OP_INC, rcid_pkg::OP_DEC,
                rcid_pkg::OP_QUERY, rcid_pkg::OP_CONTAINS: begin
                    priority if (r_id == '0) begin
                        n_st = rcid_pkg::ST_INVALID;
                    end else if (r_op == rcid_pkg::OP_CONTAINS) begin
                        n_pres = ent_live;
                    end else if (!ent_live) begin
                        n_st = rcid_pkg::ST_NOT_FOUND;
                    end else if (r_op == rcid_pkg::OP_INC) begin
                        if (ent_cnt == CountMax) begin
                            n_cnt = CountMax;
                            n_st  = rcid_pkg::ST_SAT;
                        end else begin
                            ent_we = 1'b1;
                            ent_wd = {1'b1, inc_cnt};
                            n_cnt  = inc_cnt;
                        end
                    end else if (r_op == rcid_pkg::OP_DEC) begin
                        // count of one or less frees the id
                        if (ent_cnt[COUNT_BITS-1:1] == '0) begin
                            ent_we      = 1'b1;
                            ent_wd      = {1'b0, ent_cnt};
                            fs_cmd.give = 1'b1;
                        end else begin
                            ent_we = 1'b1;
                            ent_wd = {1'b1, dec_cnt};
                            n_cnt  = dec_cnt;
                        end
                    end else begin
                        n_cnt = ent_cnt;
                    end
                end
                rcid_pkg::OP_CLEAR: begin
                    fs_cmd.clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // read address for the freed bitmap: smallest freed id on allocate
    assign fs_id = accept ? ((in_op == rcid_pkg::OP_ALLOC) ? fs_min : in_id) : r_id;

    rcid_free_set #(
        .ID_BITS (ID_BITS)
    ) u_free_set (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (fs_cmd),
        .i_id    (fs_id),
        .o_min   (fs_min),
        .o_busy  (fs_busy)
    );

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (accept) begin
            r_ent <= ent_mem[in_id];
            r_op  <= in_op;
            r_id  <= in_id;
        end
        if (fire) begin
            r_out_nid  <= n_nid;
            r_out_cnt  <= n_cnt;
            r_out_pres <= n_pres;
            r_out_st   <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_swaddr    <= '0;
            r_fresh     <= ID_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_SWEEP: begin
                    r_swaddr <= r_swaddr + 1'b1;
                    if (r_swaddr == IdLast) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        if (r_op == rcid_pkg::OP_CLEAR) begin
                            r_state  <= S_SWEEP;
                            r_swaddr <= '0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_SWEEP;
                end
            endcase
            if (fire) begin
                r_fresh <= (r_op == rcid_pkg::OP_CLEAR) ? ID_BITS'(1) : n_fresh;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_st, r_out_pres, r_out_cnt, r_out_nid});

    `ASSERT_NEXT(a_accept_exec, accept, r_state == S_EXEC, "request not executed")
    `ASSERT_NEXT(a_fire_out, fire, o_m_axis_tvalid, "result lost")
    `ASSERT_RST(a_full_result, r_out_valid && r_out_st == rcid_pkg::ST_FULL |-> r_out_nid == '0 && r_fresh == '0, "full with ids left")

endmodule
